// File: rtl/sle_pkg.sv
`timescale 1ns / 1ps
// sle_pkg: shared types, constants and lookup functions for the scancode line editor.
// Used by sle_ctrl, sle_dpath and scancode_line_editor; depends on nothing.
package sle_pkg;

	localparam int LINE_DEPTH    = 64;
	localparam int LEN_W         = $clog2(LINE_DEPTH + 1);
	localparam int ADDR_W        = $clog2(LINE_DEPTH);
	localparam int CHAR_W        = 7;
	localparam int NUM_WORDS     = 5;
	localparam int MAX_WORD_LEN  = 12;
	localparam int IDX_W         = $clog2(MAX_WORD_LEN + 1);
	localparam int CMD_W         = 3;

	localparam logic [7:0] KEY_SHIFT     = 8'h2a;
	localparam logic [7:0] KEY_BACKSPACE = 8'h0e;
	localparam logic [7:0] KEY_ENTER     = 8'h1c;
	localparam logic [7:0] MAP_SIZE      = 8'h3a;
	localparam int         RELEASE_BIT   = 7;

	localparam logic [CMD_W-1:0] NO_MATCH = CMD_W'(NUM_WORDS);

	localparam logic [CHAR_W-1:0] CHAR_LC_A   = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_LC_Z   = 7'h7a;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 7'd32;

	localparam logic [MAX_WORD_LEN*8-1:0] WORD_TEXT [NUM_WORDS] = '{
		96'("firstcommand"),
		96'("setfggreen"),
		96'("setfgred"),
		96'("setfgblue"),
		96'("setfggrey")
	};
	localparam int WORD_LEN [NUM_WORDS] = '{12, 10, 8, 9, 9};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RD,
		ST_CHK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_ECHO  = 2'd1,
		ACT_ERASE = 2'd2,
		ACT_LINE  = 2'd3
	} action_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic rd;
		logic chk;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic cmp_needed;
		logic cmp_last;
		logic out_free;
	} status_t;

	function automatic logic [CHAR_W-1:0] key_map(input logic [7:0] code);
		logic [CHAR_W-1:0] c;
		c = '0;
		if (code < MAP_SIZE) begin
			unique case (code[5:0])
				6'h02: c = 7'h31;
				6'h03: c = 7'h32;
				6'h04: c = 7'h33;
				6'h05: c = 7'h34;
				6'h06: c = 7'h35;
				6'h07: c = 7'h36;
				6'h08: c = 7'h37;
				6'h09: c = 7'h38;
				6'h0a: c = 7'h39;
				6'h0b: c = 7'h30;
				6'h0c: c = 7'h2d;
				6'h0d: c = 7'h3d;
				6'h0f: c = 7'h09;
				6'h10: c = 7'h71;
				6'h11: c = 7'h77;
				6'h12: c = 7'h65;
				6'h13: c = 7'h72;
				6'h14: c = 7'h74;
				6'h15: c = 7'h79;
				6'h16: c = 7'h75;
				6'h17: c = 7'h69;
				6'h18: c = 7'h6f;
				6'h19: c = 7'h70;
				6'h1e: c = 7'h61;
				6'h1f: c = 7'h73;
				6'h20: c = 7'h64;
				6'h21: c = 7'h66;
				6'h22: c = 7'h67;
				6'h23: c = 7'h68;
				6'h24: c = 7'h6a;
				6'h25: c = 7'h6b;
				6'h26: c = 7'h6c;
				6'h2c: c = 7'h7a;
				6'h2d: c = 7'h78;
				6'h2e: c = 7'h63;
				6'h2f: c = 7'h76;
				6'h30: c = 7'h62;
				6'h31: c = 7'h6e;
				6'h32: c = 7'h6d;
				6'h39: c = 7'h20;
				default: c = '0;
			endcase
		end
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] word_char(input int w, input logic [IDX_W-1:0] i);
		int pos;
		logic [MAX_WORD_LEN*8-1:0] s;
		s   = WORD_TEXT[w];
		pos = (WORD_LEN[w] - 1 - int'(i)) * 8;
		if (pos < 0) begin
			return '0;
		end
		return s[pos +: CHAR_W];
	endfunction

endpackage

// File: rtl/scancode_line_editor.sv
`timescale 1ns / 1ps
// scancode_line_editor: top level, set-1 scancodes in, line editing actions out.
// Depends on sle_pkg, sle_ctrl, sle_dpath (which holds sle_ram).
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------------
//   in      | in_valid / in_stall        | scan_code
//   out     | out_valid / out_stall      | action, char_code, command_index
//
// One input transfer yields one output transfer. A code is captured, executed and
// emitted; enter on a line whose length equals a command word also makes one line
// store read and compare per character before the result is emitted.
// arst_n clears shift, line length, state and output valid; the line store is not cleared.
// in_stall is high from acceptance until the result enters the output register, which
// waits while out_stall holds a previous result.
module scancode_line_editor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  scan_code,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  action,
	output logic [sle_pkg::CHAR_W-1:0]  char_code,
	output logic [sle_pkg::CMD_W-1:0]   command_index
);
	import sle_pkg::*;

	cmd_t    cmd;
	status_t st;

	sle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.st       (st)
	);

	sle_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.scan_code     (scan_code),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.action        (action),
		.char_code     (char_code),
		.command_index (command_index)
	);

endmodule

// File: rtl/sle_ram.sv
`timescale 1ns / 1ps
// sle_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module sle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/sle_ctrl.sv
`timescale 1ns / 1ps
// sle_ctrl: sequencing state machine for the line editor.
// Depends on sle_pkg; drives the datapath through cmd_t and reads status_t.
module sle_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output sle_pkg::cmd_t     cmd,
	input  sle_pkg::status_t  st
);
	import sle_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = st.cmp_needed ? ST_RD : ST_DONE;
			end
			ST_RD: begin
				state_d = ST_CHK;
			end
			ST_CHK: begin
				state_d = st.cmp_last ? ST_DONE : ST_RD;
			end
			ST_DONE: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = (state_q != ST_IDLE);
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		cmd.exec    = (state_q == ST_EXEC);
		cmd.rd      = (state_q == ST_RD);
		cmd.chk     = (state_q == ST_CHK);
		cmd.emit    = (state_q == ST_DONE) && st.out_free;
	end

endmodule

// File: rtl/sle_dpath.sv
`timescale 1ns / 1ps
// sle_dpath: shift flag, line length, line store, command word compare and output register.
// Depends on sle_pkg and sle_ram; steered by sle_ctrl.
module sle_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sle_pkg::cmd_t                   cmd,
	output sle_pkg::status_t                st,
	input  logic [7:0]                      scan_code,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      action,
	output logic [sle_pkg::CHAR_W-1:0]      char_code,
	output logic [sle_pkg::CMD_W-1:0]       command_index
);
	import sle_pkg::*;

	logic [7:0]             code_q;
	logic                   shift_q;
	logic [LEN_W-1:0]       len_q;
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       cmp_len_q;
	logic [NUM_WORDS-1:0]   mask_q;
	action_t                res_action_q;
	logic [CHAR_W-1:0]      res_char_q;
	logic [CMD_W-1:0]       res_idx_q;
	logic                   out_valid_q;
	action_t                out_action_q;
	logic [CHAR_W-1:0]      out_char_q;
	logic [CMD_W-1:0]       out_idx_q;

	logic [CHAR_W-1:0]      map_c;
	logic [CHAR_W-1:0]      typed_c;
	logic [NUM_WORDS-1:0]   len_mask;
	logic [NUM_WORDS-1:0]   mask_n;
	logic [CMD_W-1:0]       first_idx;
	logic                   wr_en;
	logic [CHAR_W-1:0]      rd_data;
	logic                   is_release;
	logic                   line_full;

	assign is_release = code_q[RELEASE_BIT];
	assign line_full  = (len_q == LEN_W'(LINE_DEPTH));
	assign map_c      = key_map(code_q);
	assign typed_c    = (shift_q && map_c >= CHAR_LC_A && map_c <= CHAR_LC_Z)
			? CHAR_W'(map_c - CASE_OFFSET) : map_c;

	always_comb begin
		for (int w = 0; w < NUM_WORDS; w++) begin
			len_mask[w] = (len_q == LEN_W'(WORD_LEN[w]));
			mask_n[w]   = mask_q[w] && (rd_data == word_char(w, idx_q));
		end
		first_idx = NO_MATCH;
		for (int w = NUM_WORDS - 1; w >= 0; w--) begin
			if (mask_n[w]) first_idx = CMD_W'(w);
		end
	end

	assign wr_en = cmd.exec && !is_release && code_q != KEY_SHIFT
			&& code_q != KEY_BACKSPACE && code_q != KEY_ENTER
			&& map_c != '0 && !line_full;

	sle_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (LINE_DEPTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (len_q[ADDR_W-1:0]),
		.wr_data (typed_c),
		.rd_en   (cmd.rd),
		.rd_addr (ADDR_W'(idx_q)),
		.rd_data (rd_data)
	);

	assign st.cmp_needed = (code_q == KEY_ENTER) && (len_mask != '0);
	assign st.cmp_last   = (idx_q == IDX_W'(cmp_len_q - 1'b1));
	assign st.out_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			code_q <= scan_code;
		end
		if (cmd.exec) begin
			res_action_q <= ACT_NONE;
			res_char_q   <= '0;
			res_idx_q    <= '0;
			idx_q        <= '0;
			mask_q       <= len_mask;
			cmp_len_q    <= len_q[IDX_W-1:0];
			if (!is_release) begin
				if (code_q == KEY_BACKSPACE) begin
					if (len_q != '0) res_action_q <= ACT_ERASE;
				end else if (code_q == KEY_ENTER) begin
					res_action_q <= ACT_LINE;
					res_idx_q    <= NO_MATCH;
				end else if (wr_en) begin
					res_action_q <= ACT_ECHO;
					res_char_q   <= typed_c;
				end
			end
		end
		if (cmd.chk) begin
			mask_q <= mask_n;
			idx_q  <= IDX_W'(idx_q + 1'b1);
			if (st.cmp_last) res_idx_q <= first_idx;
		end
		if (cmd.emit) begin
			out_action_q <= res_action_q;
			out_char_q   <= res_char_q;
			out_idx_q    <= res_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= 1'b0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				if (is_release) begin
					if (code_q[6:0] == KEY_SHIFT[6:0]) shift_q <= 1'b0;
				end else if (code_q == KEY_SHIFT) begin
					shift_q <= 1'b1;
				end else if (code_q == KEY_BACKSPACE) begin
					if (len_q != '0) len_q <= LEN_W'(len_q - 1'b1);
				end else if (code_q == KEY_ENTER) begin
					len_q <= '0;
				end else if (wr_en) begin
					len_q <= LEN_W'(len_q + 1'b1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign action        = out_action_q;
	assign char_code     = out_char_q;
	assign command_index = out_idx_q;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for scancode_line_editor, directed then random scancodes.
// Depends on sle_pkg and the scancode_line_editor RTL.
module testbench;
	import sle_pkg::*;

	localparam logic [7:0] KEY_UP_FLAG  = 8'h80;
	localparam logic [7:0] KEY_SHIFT_UP = KEY_SHIFT | KEY_UP_FLAG;
	localparam logic [7:0] KEY_TAB      = 8'h0f;
	localparam logic [7:0] KEY_RSHIFT   = 8'h36;
	localparam logic [CHAR_W-1:0] UPPER_OFFSET = 7'd32;
	localparam int PHASE_LEN    = 150;
	localparam int RANDOM_KEYS  = 1100;
	localparam int DRAIN_EVERY  = 300;

	typedef struct packed {
		action_t           act;
		logic [CHAR_W-1:0] ch;
		logic [CMD_W-1:0]  cmd;
	} edit_result_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [7:0]          scan_code = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          action;
	logic [CHAR_W-1:0]   char_code;
	logic [CMD_W-1:0]    command_index;

	// set-1 make codes 0x00..0x39, '~' marks a code with no character
	string key_row = "~~1234567890-=~\tqwertyuiop~~~~asdfghjkl~~~~~zxcvbnm~~~~~~ ";
	string cmd_words [NUM_WORDS] = '{"firstcommand", "setfggreen", "setfgred",
		"setfgblue", "setfggrey"};

	logic [CHAR_W-1:0] char_of_code [256];
	logic [7:0]        code_of_char [128];

	bit                shift_held;
	logic [CHAR_W-1:0] line_store [LINE_DEPTH];
	int                line_len;

	logic [7:0]   keys_to_send [$];
	bit           wait_idle_q [$];
	edit_result_t edits_due [$];
	edit_result_t want;
	int           keys_taken;
	int           mismatches;
	int           send_idle_pct;
	int           recv_stall_pct;

	scancode_line_editor dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1_500_000;
		$display("status: fail");
		$finish;
	end

	function automatic bit line_is(input string word);
		if (word.len() != line_len) return 1'b0;
		for (int i = 0; i < word.len(); i++) begin
			if (line_store[i] != CHAR_W'(word[i])) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic edit_result_t edit_line(input logic [7:0] code);
		edit_result_t r;
		logic [CHAR_W-1:0] c;
		r = '{ACT_NONE, '0, '0};
		c = char_of_code[code];
		if (code[7]) begin
			if ((code & ~KEY_UP_FLAG) == KEY_SHIFT) shift_held = 1'b0;
		end else if (code == KEY_SHIFT) begin
			shift_held = 1'b1;
		end else if (code == KEY_BACKSPACE) begin
			if (line_len > 0) begin
				line_len--;
				r.act = ACT_ERASE;
			end
		end else if (code == KEY_ENTER) begin
			r.cmd = NO_MATCH;
			for (int w = NUM_WORDS - 1; w >= 0; w--) begin
				if (line_is(cmd_words[w])) r.cmd = CMD_W'(w);
			end
			line_len = 0;
			r.act = ACT_LINE;
		end else if (c != '0 && line_len < LINE_DEPTH) begin
			if (shift_held && c >= "a" && c <= "z") c -= UPPER_OFFSET;
			line_store[line_len] = c;
			line_len++;
			r.act = ACT_ECHO;
			r.ch = c;
		end
		return r;
	endfunction

	function automatic logic [7:0] any_key();
		logic [7:0] k;
		do k = 8'($urandom_range(57)); while (char_of_code[k] == '0);
		return k;
	endfunction

	task automatic put(input logic [7:0] code, input bit wait_idle = 1'b0);
		keys_to_send.push_back(code);
		wait_idle_q.push_back(wait_idle);
	endtask

	task automatic press(input logic [7:0] code);
		put(code);
		if ($urandom_range(99) < 30) put(code | KEY_UP_FLAG);
	endtask

	task automatic type_text(input string text);
		for (int i = 0; i < text.len(); i++) press(code_of_char[CHAR_W'(text[i])]);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			scan_code <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				edits_due.push_back(edit_line(scan_code));
				keys_taken++;
			end
			case ((keys_taken / PHASE_LEN) % 4)
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			if (!in_valid || !in_stall) begin
				if (keys_to_send.size() != 0 && (!wait_idle_q[0] || edits_due.size() == 0)
						&& $urandom_range(99) >= send_idle_pct) begin
					in_valid  <= 1'b1;
					scan_code <= keys_to_send.pop_front();
					void'(wait_idle_q.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (edits_due.size() == 0) begin
					$error("transfer with no result due: action %0d", action);
					mismatches++;
				end else begin
					want = edits_due.pop_front();
					if (action !== want.act) begin
						$error("action: expected %0d, got %0d", want.act, action);
						mismatches++;
					end
					if (char_code !== want.ch) begin
						$error("char_code: expected %0h, got %0h", want.ch, char_code);
						mismatches++;
					end
					if (command_index !== want.cmd) begin
						$error("command_index: expected %0d, got %0d", want.cmd, command_index);
						mismatches++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		int pick;
		int n;
		int k;
		int typo_at;
		int last_key;
		int next_drain;
		bit caps;
		string text;

		for (int i = 0; i < 256; i++) char_of_code[i] = '0;
		for (int i = 0; i < 128; i++) code_of_char[i] = '0;
		for (int i = 0; i < key_row.len(); i++) begin
			if (key_row[i] != "~") begin
				char_of_code[i] = CHAR_W'(key_row[i]);
				code_of_char[CHAR_W'(key_row[i])] = 8'(i);
			end
		end

		// directed: field extremes, empty line, unknown keys, shift cases, tab, a command
		put(8'h00);
		put(8'hff);
		put(8'h7f);
		put(KEY_UP_FLAG);
		put(KEY_BACKSPACE);
		put(KEY_ENTER);
		put(KEY_RSHIFT);
		put(MAP_SIZE);
		put(KEY_SHIFT);
		put(code_of_char[CHAR_W'("q")]);
		put(code_of_char[CHAR_W'("1")]);
		put(KEY_TAB);
		put(KEY_RSHIFT | KEY_UP_FLAG);
		put(code_of_char[CHAR_W'("z")]);
		put(KEY_SHIFT_UP);
		put(code_of_char[CHAR_W'("q")]);
		put(KEY_BACKSPACE);
		put(KEY_BACKSPACE);
		put(code_of_char[CHAR_W'(" ")]);
		put(KEY_ENTER);
		type_text("setfgred");
		put(KEY_ENTER);

		last_key = keys_to_send.size() + RANDOM_KEYS;
		next_drain = keys_to_send.size();
		while (keys_to_send.size() < last_key) begin
			if (keys_to_send.size() >= next_drain) begin
				put(KEY_ENTER, 1'b1);
				next_drain += DRAIN_EVERY;
			end
			pick = $urandom_range(99);
			if (pick < 40) begin
				text = cmd_words[$urandom_range(NUM_WORDS - 1)];
				case ($urandom_range(7))
					0: text = text.substr(0, text.len() - 2);
					1: text = {text, "e"};
					2: text[$urandom_range(text.len() - 1)] = "x";
					default: ;
				endcase
				caps = ($urandom_range(9) == 0);
				typo_at = ($urandom_range(3) == 0) ? int'($urandom_range(text.len() - 1)) : -1;
				if (caps) put(KEY_SHIFT);
				for (int i = 0; i < text.len(); i++) begin
					if (i == typo_at) begin
						press(any_key());
						put(KEY_BACKSPACE);
					end
					press(code_of_char[CHAR_W'(text[i])]);
				end
				if (caps) put(KEY_SHIFT_UP);
				put(KEY_ENTER);
			end else if (pick < 60) begin
				n = $urandom_range(1, 20);
				repeat (n) begin
					k = $urandom_range(9);
					if (k == 0) put(KEY_SHIFT);
					else if (k == 1) put(KEY_SHIFT_UP);
					else if (k == 2) put(KEY_BACKSPACE);
					else press(any_key());
				end
				put(KEY_ENTER);
			end else if (pick < 63) begin
				// run the line past full, then erase one and refill
				repeat (LINE_DEPTH + $urandom_range(1, 4)) put(any_key());
				put(KEY_BACKSPACE);
				put(any_key());
				put(any_key());
				put(KEY_ENTER);
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 6)) put(8'($urandom_range(255)));
			end else begin
				n = $urandom_range(0, 3);
				repeat (n) press(any_key());
				repeat (n + $urandom_range(1, 3)) put(KEY_BACKSPACE);
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		do @(negedge clk);
		while (keys_to_send.size() != 0 || in_valid || edits_due.size() != 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule

// File: sim.f
rtl/sle_pkg.sv
rtl/sle_ram.sv
rtl/sle_ctrl.sv
rtl/sle_dpath.sv
rtl/scancode_line_editor.sv
tb/sv/testbench.sv
